/* rtl/hsv_to_rgb_convert_unit_assert.svh */
// ----------------------------------------------------------------------------
// hsv to rgb assertion macros
// shared concurrent assertion forms for the colour converter
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERT_UNIT_ASSERT_SVH
`define HSV_TO_RGB_CONVERT_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HSVRGB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define HSVRGB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/hsvrgb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// shared constants and types of the hsv to rgb converter
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

  // number of register stages from input to output register
  localparam int unsigned NSTG = 7;

  // q3.13 angle constants
  localparam logic [15:0] TWO_PI_Q13 = 16'd51472;
  localparam logic [15:0] SECT1_Q13  = 16'd8579;
  localparam logic [15:0] SECT2_Q13  = 16'd17157;
  localparam logic [15:0] SECT3_Q13  = 16'd25736;
  localparam logic [15:0] SECT4_Q13  = 16'd34315;
  localparam logic [15:0] SECT5_Q13  = 16'd42893;

  // sector width divisor and its reciprocal (floor of 2^36 / width)
  localparam longint unsigned SECT_W   = 8579;
  localparam int unsigned     RECIP_SH = 36;
  localparam logic [22:0]     RECIP_K  = 23'((64'd1 << RECIP_SH) / SECT_W);
  localparam logic [13:0]     SECT_W14 = 14'(SECT_W);

  // component order per sector: red, green, blue from c, x and zero
  typedef enum logic [2:0] {
    SEC_CXZ = 3'd0,
    SEC_XCZ = 3'd1,
    SEC_ZCX = 3'd2,
    SEC_ZXC = 3'd3,
    SEC_XZC = 3'd4,
    SEC_CZX = 3'd5
  } sector_t;

  // per-stage load enables and valid bits
  typedef struct packed {
    logic [NSTG-1:0] en;
    logic [NSTG-1:0] vld;
  } pipe_ctl_t;

endpackage
`default_nettype wire

/* rtl/hsvrgb_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsvrgb_ctrl
// valid bits and bubble-collapsing stage enables of the pipeline
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_convert_unit_assert.svh"

module hsvrgb_ctrl
  import hsvrgb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  wire logic      out_tready,
  output pipe_ctl_t      ctl
);

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] en;
  logic            in_acc;
  logic            out_acc;

  // a stage loads when it is empty or its successor loads
  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_comb begin
    vld_nxt[0] = en[0] ? in_tvalid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[NSTG-1];
  assign ctl.en     = en;
  assign ctl.vld    = vld_r;

  assign in_acc  = in_tvalid && en[0];
  assign out_acc = vld_r[NSTG-1] && out_tready;

  `HSVRGB_ASSERT_IMP(a_full_when_blocked, clk, rst_n, !en[0], &vld_r, "input blocked with a bubble in the pipe")
  `HSVRGB_ASSERT_NXT(a_count_up, clk, rst_n, in_acc && !out_acc, $countones(vld_r) == $past($countones(vld_r)) + 1, "request count did not rise")
  `HSVRGB_ASSERT_NXT(a_count_down, clk, rst_n, !in_acc && out_acc, $countones(vld_r) + 1 == $past($countones(vld_r)), "request count did not fall")

endmodule
`default_nettype wire

/* rtl/hsvrgb_hue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsvrgb_hue
// hue reduction, sector choice and the triangle weight, stages 0 to 3
// ----------------------------------------------------------------------------
module hsvrgb_hue
  import hsvrgb_pkg::*;
(
  input  wire logic        clk,
  input  wire pipe_ctl_t   ctl,
  input  wire logic [15:0] hue,
  output logic [16:0]      w,
  output sector_t          sector
);

  logic [15:0] hp0_r, hp0_nxt;
  logic [15:0] hp1_r;
  logic [18:0] q1_r, q1_nxt;
  sector_t     sec1_r, sec1_nxt;
  logic [16:0] rm2_r, rm2_nxt;
  sector_t     sec2_r;
  logic [16:0] w3_r, w3_nxt;
  sector_t     sec3_r;

  logic [38:0] recip_prod;
  logic [31:0] back_prod;
  logic [31:0] rem;
  logic [18:0] ratio;

  // stage 0: one subtraction brings the angle below two pi
  assign hp0_nxt = (hue >= TWO_PI_Q13) ? hue - TWO_PI_Q13 : hue;

  // stage 1: quotient estimate, never above the true floor and at most one below
  assign recip_prod = 39'(hp0_r) * 39'(RECIP_K);
  assign q1_nxt     = recip_prod[38:20];

  always_comb begin
    if (hp0_r <= SECT1_Q13) begin
      sec1_nxt = SEC_CXZ;
    end else if (hp0_r <= SECT2_Q13) begin
      sec1_nxt = SEC_XCZ;
    end else if (hp0_r <= SECT3_Q13) begin
      sec1_nxt = SEC_ZCX;
    end else if (hp0_r <= SECT4_Q13) begin
      sec1_nxt = SEC_ZXC;
    end else if (hp0_r <= SECT5_Q13) begin
      sec1_nxt = SEC_XZC;
    end else begin
      sec1_nxt = SEC_CZX;
    end
  end

  // stage 2: remainder check fixes the quotient, only mod 2.0 is kept
  assign back_prod = 32'(q1_r) * 32'(SECT_W14);
  assign rem       = {hp1_r, 16'd0} - back_prod;
  assign ratio     = (rem >= 32'(SECT_W14)) ? q1_r + 19'd1 : q1_r;
  assign rm2_nxt   = ratio[16:0];

  // stage 3: w = 1 - |rm - 1|
  assign w3_nxt = rm2_r[16] ? 17'h10000 - {1'b0, rm2_r[15:0]} : rm2_r;

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      hp0_r <= hp0_nxt;
    end
    if (ctl.en[1]) begin
      hp1_r  <= hp0_r;
      q1_r   <= q1_nxt;
      sec1_r <= sec1_nxt;
    end
    if (ctl.en[2]) begin
      rm2_r  <= rm2_nxt;
      sec2_r <= sec1_r;
    end
    if (ctl.en[3]) begin
      w3_r   <= w3_nxt;
      sec3_r <= sec2_r;
    end
  end

  assign w      = w3_r;
  assign sector = sec3_r;

endmodule
`default_nettype wire

/* rtl/hsvrgb_chan.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsvrgb_chan
// chroma, offset, intermediate component and channel scaling, stages 0 to 6
// ----------------------------------------------------------------------------
module hsvrgb_chan
  import hsvrgb_pkg::*;
(
  input  wire logic        clk,
  input  wire pipe_ctl_t   ctl,
  input  wire logic [8:0]  saturation,
  input  wire logic [8:0]  brightness,
  input  wire logic [16:0] w,
  input  wire sector_t     sector,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue
);

  logic [17:0]        c0_r, c1_r, c2_r, c3_r, c4_r;
  logic [8:0]         val0_r;
  logic signed [18:0] m1_r, m2_r, m3_r, m4_r;
  logic signed [18:0] m1_nxt;
  logic [17:0]        x4_r, x4_nxt;
  logic [34:0]        x_prod;
  sector_t            sec4_r;
  logic [17:0]        cr, cg, cb;
  logic signed [19:0] sr5_r, sg5_r, sb5_r;
  logic signed [19:0] m_ext;
  logic [7:0]         r6_r, g6_r, b6_r;

  // sums of 2.0 and above always clamp, so only the low 17 bits are scaled
  function automatic logic [7:0] to_chan(input logic signed [19:0] s);
    logic [24:0] t;
    logic [8:0]  q;
    t = {s[16:0], 8'd0} - {8'd0, s[16:0]};
    q = t[24:16];
    if (s[19] || s == 20'sd0) begin
      return 8'd0;
    end
    return (q[8] || s[18] || s[17]) ? 8'hFF : q[7:0];
  endfunction

  // stage 1: offset m = value - chroma, may go negative
  assign m1_nxt = $signed({2'b00, val0_r, 8'd0}) - $signed({1'b0, c0_r});

  // stage 4: x = c * w in q.16
  assign x_prod = 35'(c3_r) * 35'(w);
  assign x4_nxt = x_prod[33:16];

  // stage 5: component order by sector
  always_comb begin
    unique case (sec4_r)
      SEC_CXZ: begin cr = c4_r;  cg = x4_r;  cb = 18'd0; end
      SEC_XCZ: begin cr = x4_r;  cg = c4_r;  cb = 18'd0; end
      SEC_ZCX: begin cr = 18'd0; cg = c4_r;  cb = x4_r;  end
      SEC_ZXC: begin cr = 18'd0; cg = x4_r;  cb = c4_r;  end
      SEC_XZC: begin cr = x4_r;  cg = 18'd0; cb = c4_r;  end
      default: begin cr = c4_r;  cg = 18'd0; cb = x4_r;  end
    endcase
  end

  assign m_ext = {m4_r[18], m4_r};

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      c0_r   <= 18'(saturation) * 18'(brightness);
      val0_r <= brightness;
    end
    if (ctl.en[1]) begin
      c1_r <= c0_r;
      m1_r <= m1_nxt;
    end
    if (ctl.en[2]) begin
      c2_r <= c1_r;
      m2_r <= m1_r;
    end
    if (ctl.en[3]) begin
      c3_r <= c2_r;
      m3_r <= m2_r;
    end
    if (ctl.en[4]) begin
      x4_r   <= x4_nxt;
      c4_r   <= c3_r;
      m4_r   <= m3_r;
      sec4_r <= sector;
    end
    if (ctl.en[5]) begin
      sr5_r <= $signed({2'b00, cr}) + m_ext;
      sg5_r <= $signed({2'b00, cg}) + m_ext;
      sb5_r <= $signed({2'b00, cb}) + m_ext;
    end
    if (ctl.en[6]) begin
      r6_r <= to_chan(sr5_r);
      g6_r <= to_chan(sg5_r);
      b6_r <= to_chan(sb5_r);
    end
  end

  assign red   = r6_r;
  assign green = g6_r;
  assign blue  = b6_r;

endmodule
`default_nettype wire

/* rtl/hsv_to_rgb_convert_unit.sv */
// throughput: one request per cycle while out_tready does not stall the pipe, set by
//   the seven-stage pipeline with at most one multiplier per stage (chroma, reciprocal,
//   remainder check, chroma times weight)
// stalls collapse bubbles stage by stage, so input keeps flowing while gaps remain
// reset (rst_n low, synchronous) clears only the valid bits; the pipe is then empty
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_to_rgb_convert_unit
// streaming hsv to rgb colour converter, one pixel per clock while the output is not stalled
// ----------------------------------------------------------------------------
module hsv_to_rgb_convert_unit
  import hsvrgb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // hue[15:0], saturation[24:16], brightness[33:25]
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // red[7:0], green[15:8], blue[23:16]
);

  pipe_ctl_t   ctl;
  logic [16:0] w;
  sector_t     sector;
  logic [7:0]  red, green, blue;

  // valid bits and enables; a stage loads when empty or when its successor moves
  hsvrgb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl)
  );

  // hue path: reduce modulo two pi, divide by the sector width, triangle weight
  hsvrgb_hue u_hue (
    .clk    (clk),
    .ctl    (ctl),
    .hue    (in_tdata[15:0]),
    .w      (w),
    .sector (sector)
  );

  // colour path: chroma, offset, x, per-channel sum and scaling by 255
  hsvrgb_chan u_chan (
    .clk        (clk),
    .ctl        (ctl),
    .saturation (in_tdata[24:16]),
    .brightness (in_tdata[33:25]),
    .w          (w),
    .sector     (sector),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  assign out_tdata = {blue, green, red};

endmodule
`default_nettype wire
